// ----- rtl/stdet_pkg.sv -----
// Shared types and constants of the silence and timeout detector.
// Used by stdet_out_skid and silence_timeout_detector_core; depends on nothing.
`default_nettype none

package stdet_pkg;

    // Widths of the configuration registers.
    localparam int WINDOW_W   = 17;
    localparam int LEVEL_W    = 16;
    localparam int RATIO_W    = 7;
    localparam int SILENT_W   = 8;
    localparam int TIMEOUT_W  = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_RATIO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENT_SECONDS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SECONDS = 3'd4;

    // Register values after reset. The level of 33 is -60 dBFS of full scale.
    localparam logic [WINDOW_W-1:0]  RST_WINDOW_LENGTH   = 17'd16000;
    localparam logic [LEVEL_W-1:0]   RST_LEVEL_THRESHOLD = 16'd33;
    localparam logic [RATIO_W-1:0]   RST_CRITICAL_RATIO  = 7'd90;
    localparam logic [SILENT_W-1:0]  RST_SILENT_SECONDS  = 8'd0;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_SECONDS = 16'd5;

    // Input actions.
    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // Stop reasons.
    localparam logic [1:0] STOP_RUNNING = 2'd0;
    localparam logic [1:0] STOP_SILENCE = 2'd1;
    localparam logic [1:0] STOP_TIMEOUT = 2'd2;

    // Percentage scale and width of the silence comparison products.
    localparam int PROD_W = WINDOW_W + RATIO_W;
    localparam logic [RATIO_W-1:0] PCT_SCALE = 7'd100;

    // One result beat.
    typedef struct packed {
        logic       window_end;
        logic       window_silent;
        logic       done_res;
        logic [1:0] stop_reason;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/stdet_out_skid.sv -----
// Two-entry output stage: a result register backed by one skid register.
// Depends on stdet_pkg for the result beat type.
`default_nettype none

module stdet_out_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire stdet_pkg::t_result i_push_data,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output stdet_pkg::t_result      o_out_data,
    output logic                    o_full
);

    logic               r_out_valid;
    logic               r_skid_valid;
    stdet_pkg::t_result r_out_data;
    stdet_pkg::t_result r_skid_data;
    logic               out_take;

    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_take) begin
                r_out_data <= i_push_data;
            end else begin
                r_skid_data <= i_push_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_full      = r_skid_valid;

    // The skid register is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_skid_fills_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid && i_push && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("result pushed into a stalled output was not kept");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (!r_skid_valid && r_out_valid))
        else $error("skid entry did not move to the output register");

endmodule

`default_nettype wire

// ----- rtl/silence_timeout_detector_core.sv -----
// Top level of the silence and timeout detector for a mono capture stream.
// Depends on stdet_pkg and instantiates stdet_out_skid.
//
// Usage: samples enter on the input channel (i_in_valid / o_in_stall) with
// i_action low; an item with i_action high restarts capture and clears every
// counter. Each accepted beat yields exactly one result beat on the output
// channel (o_out_valid / i_out_stall) carrying window_end, window_silent,
// done_res and stop_reason.
// A result is registered at the edge that accepts its beat, in the skid entry if
// the output register is stalled. Throughput: one beat per cycle while o_in_stall
// is low, set by the single registered state update of window and run counters.
// Stall: a result register plus one skid entry hold results while the
// receiver stalls; the input keeps being accepted until both are full, then
// o_in_stall rises (it is registered and never depends on i_in_valid).
// Reset: synchronous and active low; the configuration registers return to
// their defaults (16000, 33, 90, 0, 5), all counters clear and no result is
// pending. Configuration writes through i_cfg_we take effect at once and are
// expected only while no beat is in flight.
`default_nettype none

module silence_timeout_detector_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_action,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  wire logic                                  i_cfg_we,
    input  wire logic [stdet_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [stdet_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic                                       o_window_end,
    output logic                                       o_window_silent,
    output logic                                       o_done_res,
    output logic [1:0]                                 o_stop_reason
);

    // The magnitude compare runs at the wider of the sample and threshold widths.
    localparam int MAG_W = (SAMPLE_BITS > stdet_pkg::LEVEL_W) ? SAMPLE_BITS
                                                                : stdet_pkg::LEVEL_W;

    // Configuration registers.
    logic [stdet_pkg::WINDOW_W-1:0]  r_window_length;
    logic [stdet_pkg::LEVEL_W-1:0]   r_level_threshold;
    logic [stdet_pkg::RATIO_W-1:0]   r_critical_ratio;
    logic [stdet_pkg::SILENT_W-1:0]  r_silent_seconds;
    logic [stdet_pkg::TIMEOUT_W-1:0] r_timeout_seconds;

    // Capture state and its next values.
    logic [stdet_pkg::WINDOW_W-1:0]  r_window_position, n_window_position;
    logic [stdet_pkg::WINDOW_W-1:0]  r_voiced_count, n_voiced_count;
    logic [stdet_pkg::SILENT_W-1:0]  r_silent_run, n_silent_run;
    logic [stdet_pkg::TIMEOUT_W-1:0] r_windows_done, n_windows_done;
    logic                            r_finished, n_finished;
    logic [1:0]                      r_end_reason, n_end_reason;

    logic                            in_accept;
    logic [SAMPLE_BITS-1:0]          sample_raw;
    logic [SAMPLE_BITS-1:0]          sample_mag;
    logic                            sample_voiced;
    logic [stdet_pkg::WINDOW_W-1:0]  wl_eff;
    logic [stdet_pkg::WINDOW_W-1:0]  voiced_inc;
    logic [stdet_pkg::WINDOW_W-1:0]  position_inc;
    logic [stdet_pkg::WINDOW_W-1:0]  quiet_count;
    logic [stdet_pkg::PROD_W-1:0]    quiet_prod;
    logic [stdet_pkg::PROD_W-1:0]    ratio_prod;
    logic                            window_is_silent;
    logic [stdet_pkg::TIMEOUT_W-1:0] windows_inc;
    logic [stdet_pkg::SILENT_W-1:0]  run_inc;
    logic                            by_silence;
    logic                            skid_full;
    stdet_pkg::t_result              step_result;
    stdet_pkg::t_result              out_result;

    assign in_accept  = i_in_valid && !skid_full;
    assign o_in_stall = skid_full;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length   <= stdet_pkg::RST_WINDOW_LENGTH;
            r_level_threshold <= stdet_pkg::RST_LEVEL_THRESHOLD;
            r_critical_ratio  <= stdet_pkg::RST_CRITICAL_RATIO;
            r_silent_seconds  <= stdet_pkg::RST_SILENT_SECONDS;
            r_timeout_seconds <= stdet_pkg::RST_TIMEOUT_SECONDS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stdet_pkg::CFG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_data[stdet_pkg::WINDOW_W-1:0];
                end
                stdet_pkg::CFG_LEVEL_THRESHOLD: begin
                    r_level_threshold <= i_cfg_data[stdet_pkg::LEVEL_W-1:0];
                end
                stdet_pkg::CFG_CRITICAL_RATIO: begin
                    r_critical_ratio <= i_cfg_data[stdet_pkg::RATIO_W-1:0];
                end
                stdet_pkg::CFG_SILENT_SECONDS: begin
                    r_silent_seconds <= i_cfg_data[stdet_pkg::SILENT_W-1:0];
                end
                stdet_pkg::CFG_TIMEOUT_SECONDS: begin
                    r_timeout_seconds <= i_cfg_data[stdet_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Two's complement magnitude. The most negative code maps to its own bit
    // pattern read as unsigned, which is exactly 2**(SAMPLE_BITS-1).
    assign sample_raw = i_sample;
    assign sample_mag = sample_raw[SAMPLE_BITS-1] ? (~sample_raw + SAMPLE_BITS'(1))
                                                  : sample_raw;

    // A zero sample is never voiced, even with a zero threshold.
    assign sample_voiced = (sample_mag != '0) &&
                           (MAG_W'(sample_mag) >= MAG_W'(r_level_threshold));

    // A programmed window length of zero behaves as one.
    assign wl_eff = (r_window_length == '0) ? stdet_pkg::WINDOW_W'(1) : r_window_length;

    assign voiced_inc   = r_voiced_count + stdet_pkg::WINDOW_W'(sample_voiced);
    assign position_inc = r_window_position + stdet_pkg::WINDOW_W'(1);

    // Silent samples of the window; if the length was lowered below the
    // voiced count mid-window, the quiet count floors at zero.
    assign quiet_count = (wl_eff > voiced_inc) ? (wl_eff - voiced_inc) : '0;

    // Silent percentage test in exact integers: quiet * 100 > ratio * length.
    assign quiet_prod = stdet_pkg::PROD_W'(quiet_count) *
                        stdet_pkg::PROD_W'(stdet_pkg::PCT_SCALE);
    assign ratio_prod = stdet_pkg::PROD_W'(r_critical_ratio) *
                        stdet_pkg::PROD_W'(wl_eff);
    assign window_is_silent = quiet_prod > ratio_prod;

    // Both window counters saturate.
    assign windows_inc = (r_windows_done != '1)
                       ? (r_windows_done + stdet_pkg::TIMEOUT_W'(1)) : r_windows_done;
    assign run_inc     = (r_silent_run != '1)
                       ? (r_silent_run + stdet_pkg::SILENT_W'(1)) : r_silent_run;

    always_comb begin
        n_window_position = r_window_position;
        n_voiced_count    = r_voiced_count;
        n_silent_run      = r_silent_run;
        n_windows_done    = r_windows_done;
        n_finished        = r_finished;
        n_end_reason      = r_end_reason;
        by_silence        = 1'b0;
        step_result       = '0;

        if (in_accept) begin
            if (i_action == stdet_pkg::ACT_RESTART) begin
                n_window_position = '0;
                n_voiced_count    = '0;
                n_silent_run      = '0;
                n_windows_done    = '0;
                n_finished        = 1'b0;
                n_end_reason      = stdet_pkg::STOP_RUNNING;
            end else if (!r_finished) begin
                n_voiced_count    = voiced_inc;
                n_window_position = position_inc;
                if (position_inc >= wl_eff) begin
                    step_result.window_end    = 1'b1;
                    step_result.window_silent = window_is_silent;
                    n_window_position         = '0;
                    n_voiced_count            = '0;
                    n_windows_done            = windows_inc;

                    // The silent run is only tracked while the silence stop is on.
                    if (r_silent_seconds != '0) begin
                        if (window_is_silent) begin
                            n_silent_run = run_inc;
                            by_silence   = (run_inc >= r_silent_seconds);
                        end else begin
                            n_silent_run = '0;
                        end
                    end

                    // Silence wins when both limits are met on the same window.
                    if (by_silence) begin
                        n_finished   = 1'b1;
                        n_end_reason = stdet_pkg::STOP_SILENCE;
                    end else if (windows_inc >= r_timeout_seconds) begin
                        n_finished   = 1'b1;
                        n_end_reason = stdet_pkg::STOP_TIMEOUT;
                    end
                end
            end
            step_result.done_res    = n_finished;
            step_result.stop_reason = n_end_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_position <= '0;
            r_voiced_count    <= '0;
            r_silent_run      <= '0;
            r_windows_done    <= '0;
            r_finished        <= 1'b0;
            r_end_reason      <= stdet_pkg::STOP_RUNNING;
        end else begin
            r_window_position <= n_window_position;
            r_voiced_count    <= n_voiced_count;
            r_silent_run      <= n_silent_run;
            r_windows_done    <= n_windows_done;
            r_finished        <= n_finished;
            r_end_reason      <= n_end_reason;
        end
    end

    stdet_out_skid u_out_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept),
        .i_push_data (step_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (out_result),
        .o_full      (skid_full)
    );

    assign o_window_end    = out_result.window_end;
    assign o_window_silent = out_result.window_silent;
    assign o_done_res      = out_result.done_res;
    assign o_stop_reason   = out_result.stop_reason;

    // A stop reason is recorded exactly when capture has ended.
    a_reason_matches_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished == (r_end_reason != stdet_pkg::STOP_RUNNING))
        else $error("stop reason disagrees with the done flag");

    // Samples that arrive after the end of capture leave the counters alone.
    a_done_freezes_windows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_action == stdet_pkg::ACT_SAMPLE && r_finished)
            |=> ($stable(r_windows_done) && $stable(r_silent_run) && r_finished))
        else $error("counters moved after capture ended");

    // Voiced samples are a subset of the samples taken in the window.
    a_voiced_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_voiced_count <= r_window_position)
        else $error("voiced count exceeds the window position");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for silence_timeout_detector_core: directed and random beats
// are checked against a behavioral model of the window and stop logic.
// Depends on stdet_pkg and the detector RTL; reads and writes no files.
`default_nettype none

module tb;

    localparam int SAMPLE_BITS  = 16;
    localparam int LATENCY      = 1;
    localparam int QUIET_LIMIT  = 400;
    localparam int RANDOM_SETUPS = 6;
    localparam int BEATS_PER_SETUP = 250;

    // Behavioral model of the detector. It keeps its own copy of the registers
    // and counters and queues the flags that each accepted beat must produce.
    class silence_judge;
        logic [stdet_pkg::WINDOW_W-1:0]  win_len;
        logic [stdet_pkg::LEVEL_W-1:0]   level;
        logic [stdet_pkg::RATIO_W-1:0]   ratio;
        logic [stdet_pkg::SILENT_W-1:0]  silent_limit;
        logic [stdet_pkg::TIMEOUT_W-1:0] timeout;

        logic [stdet_pkg::WINDOW_W-1:0]  position;
        logic [stdet_pkg::WINDOW_W-1:0]  voiced;
        logic [stdet_pkg::SILENT_W-1:0]  silent_run;
        logic [stdet_pkg::TIMEOUT_W-1:0] windows;
        logic                            finished;
        logic [1:0]                      reason;

        stdet_pkg::t_result expected_flags[$];
        int errors;
        int checked;
        int windows_closed;
        int silence_stops;
        int timeout_stops;

        function new();
            win_len      = stdet_pkg::RST_WINDOW_LENGTH;
            level        = stdet_pkg::RST_LEVEL_THRESHOLD;
            ratio        = stdet_pkg::RST_CRITICAL_RATIO;
            silent_limit = stdet_pkg::RST_SILENT_SECONDS;
            timeout      = stdet_pkg::RST_TIMEOUT_SECONDS;
            errors = 0;
            checked = 0;
            windows_closed = 0;
            silence_stops = 0;
            timeout_stops = 0;
            clear_counters();
        endfunction

        function void clear_counters();
            position   = '0;
            voiced     = '0;
            silent_run = '0;
            windows    = '0;
            finished   = 1'b0;
            reason     = stdet_pkg::STOP_RUNNING;
        endfunction

        function void set_reg(logic [stdet_pkg::CFG_IDX_W-1:0] idx,
                              logic [stdet_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                stdet_pkg::CFG_WINDOW_LENGTH:   win_len      = data[stdet_pkg::WINDOW_W-1:0];
                stdet_pkg::CFG_LEVEL_THRESHOLD: level        = data[stdet_pkg::LEVEL_W-1:0];
                stdet_pkg::CFG_CRITICAL_RATIO:  ratio        = data[stdet_pkg::RATIO_W-1:0];
                stdet_pkg::CFG_SILENT_SECONDS:  silent_limit = data[stdet_pkg::SILENT_W-1:0];
                stdet_pkg::CFG_TIMEOUT_SECONDS: timeout      = data[stdet_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the flags of one accepted input beat.
        function void note_sample(logic act, logic signed [SAMPLE_BITS-1:0] smp);
            stdet_pkg::t_result flags;
            logic [stdet_pkg::WINDOW_W-1:0] span;
            int mag;
            longint unsigned quiet;
            bit silent;
            bit by_silence;
            flags = '0;
            if (act == stdet_pkg::ACT_RESTART) begin
                clear_counters();
            end else if (!finished) begin
                // A zero window length acts as a length of one.
                span = (win_len == 0) ? stdet_pkg::WINDOW_W'(1) : win_len;
                mag = (smp < 0) ? -int'(smp) : int'(smp);
                // Zero is never voiced, not even with a zero threshold.
                if (mag != 0 && mag >= level) begin
                    voiced = voiced + stdet_pkg::WINDOW_W'(1);
                end
                position = position + stdet_pkg::WINDOW_W'(1);
                // A length lowered below the position ends the window here.
                if (position >= span) begin
                    quiet = (span > voiced) ? longint'(span - voiced) : 0;
                    silent = quiet * stdet_pkg::PCT_SCALE > longint'(ratio) * span;
                    flags.window_end = 1'b1;
                    flags.window_silent = silent;
                    windows_closed++;
                    position = '0;
                    voiced = '0;
                    if (windows != '1) begin
                        windows = windows + stdet_pkg::TIMEOUT_W'(1);
                    end
                    by_silence = 1'b0;
                    if (silent_limit != 0) begin
                        if (silent) begin
                            if (silent_run != '1) begin
                                silent_run = silent_run + stdet_pkg::SILENT_W'(1);
                            end
                            by_silence = (silent_run >= silent_limit);
                        end else begin
                            silent_run = '0;
                        end
                    end
                    // Silence wins when both limits are met on one window.
                    if (by_silence) begin
                        finished = 1'b1;
                        reason = stdet_pkg::STOP_SILENCE;
                        silence_stops++;
                    end else if (windows >= timeout) begin
                        finished = 1'b1;
                        reason = stdet_pkg::STOP_TIMEOUT;
                        timeout_stops++;
                    end
                end
            end
            flags.done_res = finished;
            flags.stop_reason = reason;
            expected_flags.push_back(flags);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= 20) begin
                $display("mismatch on %s at result %0d: got %0d, want %0d",
                         what, checked, got, want);
            end
        endtask

        task check_flags(stdet_pkg::t_result got);
            stdet_pkg::t_result want;
            if (expected_flags.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1, 0);
                return;
            end
            want = expected_flags.pop_front();
            checked++;
            if (got.window_end !== want.window_end) begin
                report_mismatch("window_end", got.window_end, want.window_end);
            end
            if (got.window_silent !== want.window_silent) begin
                report_mismatch("window_silent", got.window_silent, want.window_silent);
            end
            if (got.done_res !== want.done_res) begin
                report_mismatch("done_res", got.done_res, want.done_res);
            end
            if (got.stop_reason !== want.stop_reason) begin
                report_mismatch("stop_reason", got.stop_reason, want.stop_reason);
            end
        endtask
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic                                 i_action;
    logic signed [SAMPLE_BITS-1:0]        i_sample;
    logic                                 i_cfg_we;
    logic [stdet_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [stdet_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic                                 o_window_end;
    logic                                 o_window_silent;
    logic                                 o_done_res;
    logic [1:0]                           o_stop_reason;

    silence_judge judge;
    bit idle_on;
    int beats_sent;
    int setups_run;

    silence_timeout_detector_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_window_end   (o_window_end),
        .o_window_silent(o_window_silent),
        .o_done_res     (o_done_res),
        .o_stop_reason  (o_stop_reason)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offers one input beat and returns at the edge that accepts it. The
    // offer may be preceded by a short burst with valid low. Valid stays high
    // after acceptance so that back-to-back beats follow without a gap.
    task automatic send_beat(input logic act, input logic signed [SAMPLE_BITS-1:0] smp);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_sample   <= smp;
        do @(posedge i_clk); while (o_in_stall);
        judge.note_sample(act, smp);
        beats_sent++;
    endtask

    // Drops valid and waits until every pending result beat has come back, so
    // that the block is idle for register writes.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (judge.expected_flags.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Holds the write enable high across a run of writes; end_writes drops it.
    task automatic write_reg(input logic [stdet_pkg::CFG_IDX_W-1:0] idx,
                             input logic [stdet_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        judge.set_reg(idx, data);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_setup(input int win, input int lvl, input int pct,
                              input int sil, input int tmo);
        write_reg(stdet_pkg::CFG_WINDOW_LENGTH,   stdet_pkg::CFG_DATA_W'(win));
        write_reg(stdet_pkg::CFG_LEVEL_THRESHOLD, stdet_pkg::CFG_DATA_W'(lvl));
        write_reg(stdet_pkg::CFG_CRITICAL_RATIO,  stdet_pkg::CFG_DATA_W'(pct));
        write_reg(stdet_pkg::CFG_SILENT_SECONDS,  stdet_pkg::CFG_DATA_W'(sil));
        write_reg(stdet_pkg::CFG_TIMEOUT_SECONDS, stdet_pkg::CFG_DATA_W'(tmo));
        end_writes();
        setups_run++;
    endtask

    // Picks a sample. A higher hush level favors samples below the threshold,
    // so that some capture segments run into the silence stop.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
            input logic [stdet_pkg::LEVEL_W-1:0] lvl, input int hush);
        int m;
        if ($urandom_range(0, 3) < hush) begin
            m = (lvl > 1) ? $urandom_range(0, lvl - 1) : 0;
            return $urandom_range(0, 1) ? SAMPLE_BITS'(-m) : SAMPLE_BITS'(m);
        end
        case ($urandom_range(0, 5))
            0: m = 0;
            1: m = $urandom_range(0, 1) ? 32767 : 32768;
            2, 3: begin
                m = int'(lvl) + int'($urandom_range(0, 4)) - 2;
                if (m < 0) m = 0;
                if (m > 32768) m = 32768;
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
        return $urandom_range(0, 1) ? SAMPLE_BITS'(-m) : SAMPLE_BITS'(m);
    endfunction

    // Receiver side: checks every accepted result beat and stalls in random
    // bursts while idling is on.
    initial begin : result_side
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                judge.check_flags({o_window_end, o_window_silent, o_done_res, o_stop_reason});
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Ends the run when neither channel moves a beat for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int setup;
        int live_beats;
        int hush;
        int win;
        int lvl;
        int pct;
        int sil;
        int tmo;
        logic act;
        logic signed [SAMPLE_BITS-1:0] smp;

        judge = new();
        idle_on = 1'b1;
        beats_sent = 0;
        setups_run = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_action    <= stdet_pkg::ACT_SAMPLE;
        i_sample    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= stdet_pkg::CFG_WINDOW_LENGTH;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A zero window length acts as one, and a zero timeout ends capture
        // on the first window. The top threshold only lets -32768 through.
        // Samples after done are ignored until the restart.
        load_setup(0, 32768, 100, 255, 0);
        send_beat(stdet_pkg::ACT_SAMPLE, -16'sd32768);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd32767);
        send_beat(stdet_pkg::ACT_RESTART, 16'sh1234);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd32767);
        send_beat(stdet_pkg::ACT_SAMPLE, -16'sd32768);
        settle();

        // The first window is silent and also meets the timeout, so silence
        // must win. After a restart a voiced window ends by timeout.
        load_setup(2, 0, 0, 1, 1);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd0);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd0);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd5);
        send_beat(stdet_pkg::ACT_RESTART, -16'sd1);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd7);
        send_beat(stdet_pkg::ACT_SAMPLE, -16'sd7);
        send_beat(stdet_pkg::ACT_RESTART, 16'sd0);
        settle();

        // With the silence stop off, seven beats go into a ten-beat window;
        // then the length drops to three, below both the position and the
        // voiced count, so the next beat closes a window with no quiet beats.
        load_setup(10, 100, 90, 0, 65535);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd200);
        send_beat(stdet_pkg::ACT_SAMPLE, -16'sd200);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd32767);
        send_beat(stdet_pkg::ACT_SAMPLE, -16'sd32768);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd100);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd99);
        send_beat(stdet_pkg::ACT_SAMPLE, -16'sd1);
        settle();
        write_reg(stdet_pkg::CFG_WINDOW_LENGTH, stdet_pkg::CFG_DATA_W'(3));
        end_writes();
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd0);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd0);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd0);
        send_beat(stdet_pkg::ACT_SAMPLE, 16'sd0);
        settle();

        // The longest window only sees a few beats before a restart.
        load_setup(131071, 1, 50, 3, 2);
        send_beat(stdet_pkg::ACT_SAMPLE, SAMPLE_BITS'($urandom));
        send_beat(stdet_pkg::ACT_SAMPLE, SAMPLE_BITS'($urandom));
        send_beat(stdet_pkg::ACT_SAMPLE, SAMPLE_BITS'($urandom));
        send_beat(stdet_pkg::ACT_RESTART, SAMPLE_BITS'($urandom));
        settle();

        // Random part: short windows so that windows close often, restarts
        // that are frequent once capture is done and rare while it runs.
        // The last setup runs without idling on either side.
        for (setup = 0; setup < RANDOM_SETUPS; setup++) begin
            idle_on = (setup < RANDOM_SETUPS - 1);
            case ($urandom_range(0, 3))
                0: win = 1;
                1, 2: win = $urandom_range(2, 8);
                default: win = $urandom_range(9, 40);
            endcase
            case ($urandom_range(0, 3))
                0: lvl = 0;
                1: lvl = 32768;
                2: lvl = $urandom_range(1, 64);
                default: lvl = $urandom_range(0, 32768);
            endcase
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 100;
                default: pct = $urandom_range(0, 100);
            endcase
            case ($urandom_range(0, 3))
                0: sil = 0;
                1: sil = 255;
                default: sil = $urandom_range(1, 4);
            endcase
            tmo = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 10);
            load_setup(win, lvl, pct, sil, tmo);
            hush = $urandom_range(0, 3);
            live_beats = 0;
            while (live_beats < BEATS_PER_SETUP) begin
                if (judge.finished ? ($urandom_range(0, 2) == 0)
                                   : ($urandom_range(0, 39) == 0)) begin
                    act = stdet_pkg::ACT_RESTART;
                    smp = SAMPLE_BITS'($urandom);
                    hush = $urandom_range(0, 3);
                end else begin
                    act = stdet_pkg::ACT_SAMPLE;
                    smp = pick_sample(judge.level, hush);
                end
                live_beats++;
                send_beat(act, smp);
            end
            settle();
        end

        repeat (LATENCY + 4) @(posedge i_clk);
        if (judge.expected_flags.size() != 0) begin
            judge.report_mismatch("result beats still pending",
                                  0, judge.expected_flags.size());
        end
        $display("covered %0d input beats over %0d register setups, %0d result beats checked",
                 beats_sent, setups_run, judge.checked);
        $display("saw %0d closed windows, %0d silence stops, %0d timeout stops",
                 judge.windows_closed, judge.silence_stops, judge.timeout_stops);
        if (judge.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
